// ===== rtl/cfb_pkg.sv =====
// cfb_pkg: shared types, constants and helper functions for the frame builder
// used by cfb_front, cfb_queue, cfb_back and the top level; no dependencies
`timescale 1ns / 1ps

package cfb_pkg;

  localparam int LEN_W  = 14;
  localparam int BYTE_W = 8;
  localparam int CRC_W  = 16;
  localparam int FRAC_W = 28;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [CRC_W-1:0]  CRC_INIT    = 16'hFFFF;
  localparam logic [CRC_W-1:0]  CRC_POLY    = 16'hA001;
  localparam logic [LEN_W-1:0]  MAX_LEN_RST = 14'd950;
  localparam logic [LEN_W-1:0]  LEN_WRAP    = 14'd10000;
  // ceil(2^24 / 1000): fixed-point thousands fraction for digit extraction
  localparam logic [FRAC_W-1:0] DEC_RECIP   = 28'd16778;

  localparam logic [BYTE_W-1:0] CH_HASH = 8'h23;
  localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30;
  localparam logic [BYTE_W-1:0] CH_A    = 8'h41;
  localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;

  // one unit of work handed from the front to the back
  typedef struct packed {
    logic                 is_start;
    logic                 fin;
    logic                 ok;
    logic [BYTE_W-1:0]    data;
    logic [FRAC_W-1:0]    frac;
    logic [CRC_W-1:0]     crc;
  } cfb_job_t;

  function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = {8'h00, crc[15:8]} ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] nib);
    logic [BYTE_W-1:0] r;
    if (nib < 4'd10) begin
      r = CH_ZERO + {4'h0, nib};
    end else begin
      r = CH_A + {4'h0, nib} - 8'd10;
    end
    return r;
  endfunction

endpackage

// ===== rtl/cfb_queue.sv =====
// cfb_queue: short job queue between the front and the back
// depends on cfb_pkg for the job type and depth
`timescale 1ns / 1ps

module cfb_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  cfb_pkg::cfb_job_t push_job,
  output logic              full,
  input  logic              pop,
  output cfb_pkg::cfb_job_t head,
  output logic              empty
);
  import cfb_pkg::*;

  cfb_job_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == QCNT_W'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/cfb_front.sv =====
// cfb_front: takes requests, tracks the open frame and the running crc,
// and turns each request into a job for the back; depends on cfb_pkg
`timescale 1ns / 1ps

module cfb_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  input  logic                      in_cmd,
  input  logic [cfb_pkg::LEN_W-1:0] in_payload_length,
  input  logic [cfb_pkg::BYTE_W-1:0] in_data_byte,
  input  logic                      cfg_we,
  input  logic [cfb_pkg::LEN_W-1:0] cfg_max_length,
  input  logic                      q_full,
  output logic                      q_push,
  output cfb_pkg::cfb_job_t         q_job
);
  import cfb_pkg::*;

  logic [LEN_W-1:0] max_len_r;
  logic [CRC_W-1:0] crc_r, crc_nxt;
  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic             open_r, open_nxt;
  logic             ok_r, ok_nxt;

  logic             accept;
  logic             data_live;
  logic [LEN_W-1:0] shown;
  logic [CRC_W-1:0] crc_folded;
  logic             len_ok;

  always_comb begin
    accept     = in_push && !q_full;
    data_live  = open_r && (rem_r != '0);
    shown      = (in_payload_length >= LEN_WRAP) ? in_payload_length - LEN_WRAP
                                                 : in_payload_length;
    crc_folded = crc_fold(crc_r, in_data_byte);
    len_ok     = (in_payload_length <= max_len_r);

    q_job = '0;
    if (!in_cmd) begin
      q_job.is_start = 1'b1;
      q_job.fin      = (in_payload_length == '0);
      q_job.ok       = len_ok;
      q_job.frac     = FRAC_W'(shown) * DEC_RECIP;
      q_job.crc      = CRC_INIT;
    end else begin
      q_job.fin      = (rem_r == LEN_W'(1));
      q_job.ok       = ok_r;
      q_job.data     = in_data_byte;
      q_job.crc      = crc_folded;
    end
    // data outside an open frame is taken and dropped
    q_push = accept && (!in_cmd || data_live);

    crc_nxt  = crc_r;
    rem_nxt  = rem_r;
    open_nxt = open_r;
    ok_nxt   = ok_r;
    if (accept && !in_cmd) begin
      crc_nxt  = CRC_INIT;
      rem_nxt  = in_payload_length;
      open_nxt = (in_payload_length != '0);
      ok_nxt   = len_ok;
    end else if (accept && data_live) begin
      crc_nxt  = crc_folded;
      rem_nxt  = rem_r - 1'b1;
      open_nxt = (rem_r != LEN_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RST;
      crc_r     <= CRC_INIT;
      rem_r     <= '0;
      open_r    <= 1'b0;
      ok_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_len_r <= cfg_max_length;
      end
      crc_r  <= crc_nxt;
      rem_r  <= rem_nxt;
      open_r <= open_nxt;
      ok_r   <= ok_nxt;
    end
  end

endmodule

// ===== rtl/cfb_back.sv =====
// cfb_back: walks each job through its byte sequence into the result register,
// one byte a cycle while out_pop does not stall it; depends on cfb_pkg
`timescale 1ns / 1ps

module cfb_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_empty,
  input  cfb_pkg::cfb_job_t          q_head,
  output logic                       q_pop,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic [cfb_pkg::BYTE_W-1:0] out_byte,
  output logic                       out_last,
  output logic                       out_ok
);
  import cfb_pkg::*;

  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] ST_HASH_A    = 4'd0;
  localparam logic [STEP_W-1:0] ST_HASH_B    = 4'd1;
  localparam logic [STEP_W-1:0] ST_DIG_FIRST = 4'd2;
  localparam logic [STEP_W-1:0] ST_DIG_LAST  = 4'd5;
  localparam logic [STEP_W-1:0] ST_DATA      = 4'd6;
  localparam logic [STEP_W-1:0] ST_HEX_0     = 4'd7;
  localparam logic [STEP_W-1:0] ST_HEX_1     = 4'd8;
  localparam logic [STEP_W-1:0] ST_HEX_2     = 4'd9;
  localparam logic [STEP_W-1:0] ST_HEX_3     = 4'd10;
  localparam logic [STEP_W-1:0] ST_CR        = 4'd11;
  localparam logic [STEP_W-1:0] ST_LF        = 4'd12;

  logic              busy_r, busy_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [FRAC_W-1:0] frac_r, frac_nxt;
  logic [CRC_W-1:0]  crc_r, crc_nxt;
  logic [BYTE_W-1:0] data_r, data_nxt;
  logic              fin_r, fin_nxt;
  logic              ok_r, ok_nxt;

  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_last_r;
  logic              out_ok_r;

  logic              out_ready;
  logic              emit;
  logic              done;
  logic              load;
  logic [BYTE_W-1:0] cur_byte;

  always_comb begin
    out_ready = !out_valid_r || out_pop;
    emit      = busy_r && out_ready;
    done      = (step_r == ST_LF) ||
                (((step_r == ST_DIG_LAST) || (step_r == ST_DATA)) && !fin_r);
    load      = !q_empty && (!busy_r || (emit && done));
    q_pop     = load;

    case (step_r)
      ST_HASH_A, ST_HASH_B: cur_byte = CH_HASH;
      ST_DATA:              cur_byte = data_r;
      ST_HEX_0:             cur_byte = hex_digit(crc_r[15:12]);
      ST_HEX_1:             cur_byte = hex_digit(crc_r[11:8]);
      ST_HEX_2:             cur_byte = hex_digit(crc_r[7:4]);
      ST_HEX_3:             cur_byte = hex_digit(crc_r[3:0]);
      ST_CR:                cur_byte = CH_CR;
      ST_LF:                cur_byte = CH_LF;
      default: begin
        // decimal digits: integer part of the scaled fraction
        if (step_r inside {[ST_DIG_FIRST:ST_DIG_LAST]}) begin
          cur_byte = CH_ZERO + {4'h0, frac_r[27:24]};
        end else begin
          cur_byte = '0;
        end
      end
    endcase

    busy_nxt = busy_r;
    step_nxt = step_r;
    frac_nxt = frac_r;
    crc_nxt  = crc_r;
    data_nxt = data_r;
    fin_nxt  = fin_r;
    ok_nxt   = ok_r;
    if (load) begin
      busy_nxt = 1'b1;
      step_nxt = q_head.is_start ? ST_HASH_A : ST_DATA;
      frac_nxt = q_head.frac;
      crc_nxt  = q_head.crc;
      data_nxt = q_head.data;
      fin_nxt  = q_head.fin;
      ok_nxt   = q_head.ok;
    end else if (emit) begin
      if (done) begin
        busy_nxt = 1'b0;
      end
      // the last length digit skips the data slot
      step_nxt = (step_r == ST_DIG_LAST) ? ST_HEX_0 : step_r + 1'b1;
      if (step_r inside {[ST_DIG_FIRST:ST_DIG_LAST]}) begin
        frac_nxt = FRAC_W'({frac_r[23:0], 3'b000}) + FRAC_W'({frac_r[23:0], 1'b0});
      end
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    frac_r <= frac_nxt;
    crc_r  <= crc_nxt;
    data_r <= data_nxt;
    fin_r  <= fin_nxt;
    ok_r   <= ok_nxt;
    if (emit) begin
      out_byte_r <= cur_byte;
      out_last_r <= (step_r == ST_LF);
      out_ok_r   <= ok_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      if (out_ready) begin
        out_valid_r <= emit;
      end
    end
  end

  assign out_empty = !out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;
  assign out_ok    = out_ok_r;

endmodule

// ===== rtl/cloud_frame_builder_crc16_top.sv =====
// cloud_frame_builder_crc16_top: frame builder with running crc16 trailer
// depends on cfb_pkg, cfb_front, cfb_queue and cfb_back
//
//   channel   handshake         payload
//   in        in_push / in_full in_cmd, in_payload_length, in_data_byte
//   out       out_pop / out_empty out_byte, out_last, out_ok
//   cfg       cfg_we            cfg_max_length
//
// a request is taken every cycle while the job queue (4 deep) has room;
// each request yields 0 to 12 bytes, and the back end emits one byte a
// cycle unless out_pop stalls, so sustained output is one byte per cycle.
// a request's first byte passes the queue, job registers and result register.
// reset is synchronous and active low, with no clearing pass.
// a stalled out_pop holds the result register and backs up through the queue.
`timescale 1ns / 1ps

module cloud_frame_builder_crc16_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic                        in_cmd,
  input  logic [cfb_pkg::LEN_W-1:0]   in_payload_length,
  input  logic [cfb_pkg::BYTE_W-1:0]  in_data_byte,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [cfb_pkg::BYTE_W-1:0]  out_byte,
  output logic                        out_last,
  output logic                        out_ok,
  input  logic                        cfg_we,
  input  logic [cfb_pkg::LEN_W-1:0]   cfg_max_length
);
  import cfb_pkg::*;

  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_empty;
  cfb_job_t q_job;
  cfb_job_t q_head;

  assign in_full = q_full;

  cfb_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_cmd            (in_cmd),
    .in_payload_length (in_payload_length),
    .in_data_byte      (in_data_byte),
    .cfg_we            (cfg_we),
    .cfg_max_length    (cfg_max_length),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_job             (q_job)
  );

  cfb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  cfb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .out_ok    (out_ok)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("job pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("job popped from an empty queue");

  a_last_is_lf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_last && !out_empty) |-> (out_byte == CH_LF))
    else $error("last byte of a frame is not LF");

  a_start_makes_job: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full && !in_cmd) |-> q_push)
    else $error("start request produced no job");

endmodule

// ===== bench/tb_cloud_frame_builder_crc16_top.sv =====
// tb_cloud_frame_builder_crc16_top: self-checking bench for the hj212-style frame builder
// predicts every framed byte (length digits, echoed payload, crc16 trailer) and checks it
// depends on cfb_pkg and cloud_frame_builder_crc16_top
`timescale 1ns / 1ps

module tb_cloud_frame_builder_crc16_top;
  import cfb_pkg::*;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  localparam logic [7:0]  ASCII_HASH  = 8'h23;
  localparam logic [7:0]  ASCII_ZERO  = 8'h30;
  localparam logic [7:0]  ASCII_HEX_A = 8'h41;
  localparam logic [7:0]  ASCII_CR    = 8'h0D;
  localparam logic [7:0]  ASCII_LF    = 8'h0A;
  localparam logic [15:0] CRC_SEED    = 16'hFFFF;
  localparam logic [15:0] CRC_REFL_POLY = 16'hA001;
  localparam logic [LEN_W-1:0] MAX_LEN_AT_RESET = 14'd950;
  localparam int LEN_DIGIT_WRAP = 10000;
  localparam int DRAIN_LIMIT    = 20000;
  localparam int SETTLE_CYCLES  = 12;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic       ok;
  } frame_byte_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_push = 1'b0;
  logic              in_full;
  logic              in_cmd = 1'b0;
  logic [LEN_W-1:0]  in_payload_length = '0;
  logic [BYTE_W-1:0] in_data_byte = '0;
  logic              out_empty;
  logic              out_pop = 1'b0;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last;
  logic              out_ok;
  logic              cfg_we = 1'b0;
  logic [LEN_W-1:0]  cfg_max_length = '0;

  // shadow of the frame builder state
  logic [15:0]      crc_run = CRC_SEED;
  logic [LEN_W-1:0] bytes_left = '0;
  logic             frame_live = 1'b0;
  logic             frame_in_limit = 1'b0;
  logic [LEN_W-1:0] max_len_set = MAX_LEN_AT_RESET;

  frame_byte_t frame_bytes_due[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int failures = 0;
  int requests_sent = 0;
  int productive_requests = 0;
  int bytes_checked = 0;
  int frames_closed = 0;
  int frames_aborted = 0;
  int config_writes = 0;

  cloud_frame_builder_crc16_top uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_cmd            (in_cmd),
    .in_payload_length (in_payload_length),
    .in_data_byte      (in_data_byte),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_byte          (out_byte),
    .out_last          (out_last),
    .out_ok            (out_ok),
    .cfg_we            (cfg_we),
    .cfg_max_length    (cfg_max_length)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    int i;
    c = {8'h00, crc[15:8] ^ b};
    for (i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_REFL_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
    return (nib < 4'd10) ? ASCII_ZERO + {4'h0, nib} : ASCII_HEX_A + {4'h0, nib} - 8'd10;
  endfunction

  function automatic void push_byte(input logic [7:0] value, input logic last);
    frame_bytes_due.push_back('{value: value, last: last, ok: frame_in_limit});
  endfunction

  function automatic void close_frame();
    push_byte(hex_ascii(crc_run[15:12]), 1'b0);
    push_byte(hex_ascii(crc_run[11:8]), 1'b0);
    push_byte(hex_ascii(crc_run[7:4]), 1'b0);
    push_byte(hex_ascii(crc_run[3:0]), 1'b0);
    push_byte(ASCII_CR, 1'b0);
    push_byte(ASCII_LF, 1'b1);
    frame_live = 1'b0;
    frames_closed++;
  endfunction

  // returns the number of bytes that this request adds to the output stream
  function automatic int predict_frame_bytes(input logic cmd, input logic [LEN_W-1:0] len,
                                             input logic [7:0] data);
    int before_size;
    int shown;
    before_size = frame_bytes_due.size();
    if (cmd == CMD_START) begin
      if (frame_live) frames_aborted++;
      shown = int'(len) % LEN_DIGIT_WRAP;
      crc_run = CRC_SEED;
      bytes_left = len;
      frame_in_limit = (len <= max_len_set);
      frame_live = 1'b1;
      push_byte(ASCII_HASH, 1'b0);
      push_byte(ASCII_HASH, 1'b0);
      push_byte(ASCII_ZERO + 8'(shown / 1000 % 10), 1'b0);
      push_byte(ASCII_ZERO + 8'(shown / 100 % 10), 1'b0);
      push_byte(ASCII_ZERO + 8'(shown / 10 % 10), 1'b0);
      push_byte(ASCII_ZERO + 8'(shown % 10), 1'b0);
      if (len == '0) close_frame();
    end else if (frame_live && bytes_left != '0) begin
      crc_run = crc_next(crc_run, data);
      push_byte(data, 1'b0);
      bytes_left = bytes_left - 1'b1;
      if (bytes_left == '0) close_frame();
    end
    return frame_bytes_due.size() - before_size;
  endfunction

  // entered and left just after a rising edge
  task automatic send_request(input logic cmd, input logic [LEN_W-1:0] len,
                              input logic [7:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_cmd <= cmd;
    in_payload_length <= len;
    in_data_byte <= data;
    @(negedge clk);
    while (in_full) @(negedge clk);
    @(posedge clk);
    requests_sent++;
    if (predict_frame_bytes(cmd, len, data) > 0) productive_requests++;
  endtask

  task automatic wait_until_idle();
    int waited;
    waited = 0;
    in_push <= 1'b0;
    while (frame_bytes_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (frame_bytes_due.size() != 0) begin
      $error("%0d expected frame bytes never arrived", frame_bytes_due.size());
      failures++;
      frame_bytes_due.delete();
    end
    // ignored requests may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_length(input logic [LEN_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_max_length <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    max_len_set = value;
    config_writes++;
  endtask

  task automatic test_zero_length();
    send_request(CMD_START, 14'd0, 8'h00);
  endtask

  task automatic test_stray_data_and_abort();
    send_request(CMD_DATA, 14'd0, 8'h77);
    send_request(CMD_START, 14'd2, 8'hFF);
    send_request(CMD_DATA, 14'h3FFF, 8'h31);
    send_request(CMD_START, 14'd1, 8'h00);
    send_request(CMD_DATA, 14'd5, 8'hFF);
    // frame already closed, so this one is dropped
    send_request(CMD_DATA, 14'd5, 8'h42);
  endtask

  task automatic test_byte_extremes();
    send_request(CMD_START, 14'd3, 8'h00);
    send_request(CMD_DATA, 14'd0, 8'h00);
    send_request(CMD_DATA, 14'h3FFF, 8'hFF);
    send_request(CMD_DATA, 14'd0, 8'h5A);
  endtask

  task automatic test_long_lengths();
    send_request(CMD_START, 14'd9999, 8'h00);
    send_request(CMD_DATA, 14'd0, 8'h12);
    // five-digit lengths show modulo 10000
    send_request(CMD_START, 14'h3FFF, 8'hFF);
    send_request(CMD_START, 14'd10000, 8'h00);
    send_request(CMD_START, 14'd0, 8'h00);
  endtask

  task automatic test_limit_extremes();
    wait_until_idle();
    write_max_length(14'd0);
    send_request(CMD_START, 14'd0, 8'h00);
    send_request(CMD_START, 14'd1, 8'h00);
    send_request(CMD_DATA, 14'd0, 8'h80);
    wait_until_idle();
    write_max_length(14'd9999);
    send_request(CMD_START, 14'd9999, 8'h00);
    send_request(CMD_START, 14'd1, 8'h00);
    send_request(CMD_DATA, 14'd0, 8'h01);
  endtask

  task automatic run_random_phase(input int idle_pct, input int stall_pct,
                                  input logic [LEN_W-1:0] limit, input int target);
    int goal;
    int pick;
    int sent_bytes;
    int k;
    logic [LEN_W-1:0] len;
    wait_until_idle();
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    write_max_length(limit);
    goal = productive_requests + target;
    while (productive_requests < goal) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        len = ($urandom_range(99) < 85) ? LEN_W'($urandom_range(12))
                                        : LEN_W'($urandom_range(48, 13));
        // now and then a frame is cut short and later aborted
        sent_bytes = ($urandom_range(9) == 0) ? $urandom_range(int'(len)) : int'(len);
        send_request(CMD_START, len, 8'($urandom_range(255)));
        for (k = 0; k < sent_bytes; k++) begin
          send_request(CMD_DATA, LEN_W'($urandom_range(16383)), 8'($urandom_range(255)));
        end
      end else if (pick < 90) begin
        send_request(CMD_DATA, LEN_W'($urandom_range(16383)), 8'($urandom_range(255)));
      end else begin
        send_request(CMD_START, LEN_W'($urandom_range(16383)), 8'($urandom_range(255)));
        repeat ($urandom_range(3)) begin
          send_request(CMD_DATA, LEN_W'($urandom_range(16383)), 8'($urandom_range(255)));
        end
      end
    end
  endtask

  always @(posedge clk) begin
    out_pop <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(negedge clk) begin : check_frame_bytes
    frame_byte_t due;
    if (rst_n && out_pop && !out_empty) begin
      if (frame_bytes_due.size() == 0) begin
        $error("unexpected frame byte %02h (last %0b, ok %0b)", out_byte, out_last, out_ok);
        failures++;
      end else begin
        due = frame_bytes_due.pop_front();
        bytes_checked++;
        if (out_byte !== due.value) begin
          $error("out_byte: expected %02h, got %02h", due.value, out_byte);
          failures++;
        end
        if (out_last !== due.last) begin
          $error("out_last: expected %0b, got %0b", due.last, out_last);
          failures++;
        end
        if (out_ok !== due.ok) begin
          $error("out_ok: expected %0b, got %0b", due.ok, out_ok);
          failures++;
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_zero_length();
    test_stray_data_and_abort();
    test_byte_extremes();
    test_long_lengths();
    test_limit_extremes();
    run_random_phase(0, 0, 14'd6, 45);
    run_random_phase(47, 0, 14'd950, 45);
    run_random_phase(0, 47, 14'h3FFF, 45);
    run_random_phase(23, 23, 14'd4, 45);
    wait_until_idle();
    $display("covered %0d requests (%0d producing output), %0d frame bytes checked",
             requests_sent, productive_requests, bytes_checked);
    $display("%0d frames completed, %0d aborted, %0d max_length writes",
             frames_closed, frames_aborted, config_writes);
    if (failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/cfb_pkg.sv
rtl/cfb_queue.sv
rtl/cfb_front.sv
rtl/cfb_back.sv
rtl/cloud_frame_builder_crc16_top.sv
bench/tb_cloud_frame_builder_crc16_top.sv
